// ===== sv/bhcm_pkg.sv =====
// ----------------------------------------------------------------------------
// bhcm_pkg: shared types and constants of the breakpoint heat colormap
// Fraction format, divider sizing, register map and segment codes.
// ----------------------------------------------------------------------------
package bhcm_pkg;

    // Q0.FRAC_W fractions; ONE needs one bit more
    localparam int FRAC_W = 16;
    localparam int ONE_W  = FRAC_W + 1;
    localparam int QUO_W  = 8;
    // num * 255 fits in ONE_W + QUO_W bits
    localparam int REM_W  = ONE_W + QUO_W;

    localparam logic [ONE_W-1:0] ONE  = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [QUO_W-1:0] QMAX = '1;

    // APB register map
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_LOW  = 2'd0;
    localparam logic [1:0] REG_MID  = 2'd1;
    localparam logic [1:0] REG_HIGH = 2'd2;

    localparam logic [FRAC_W-1:0] LOW_RST  = FRAC_W'(655);
    localparam logic [FRAC_W-1:0] MID_RST  = FRAC_W'(3277);
    localparam logic [FRAC_W-1:0] HIGH_RST = FRAC_W'(9830);

    // pipeline depth from accepted start to result strobe
    localparam int LATENCY = QUO_W + 3;

    typedef struct packed {
        logic [FRAC_W-1:0] low;
        logic [FRAC_W-1:0] mid;
        logic [FRAC_W-1:0] high;
    } t_breaks;

    typedef enum logic [1:0] {
        SEG_HOT,
        SEG_WARM,
        SEG_COOL,
        SEG_COLD
    } t_seg;

    typedef struct packed {
        t_seg             seg;
        logic [ONE_W-1:0] den;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } t_div_data;

endpackage

// ===== sv/bhcm_regs.sv =====
// ----------------------------------------------------------------------------
// bhcm_regs: breakpoint register file
// APB write/read of the low, mid and high breakpoints.
// ----------------------------------------------------------------------------
module bhcm_regs
    import bhcm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_breaks           o_breaks
);

    t_breaks    r_breaks;
    t_breaks    n_breaks;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[3:2];

    always_comb begin
        n_breaks = r_breaks;
        if (wr_en) begin
            unique case (idx)
                REG_LOW:  n_breaks.low  = pwdata[FRAC_W-1:0];
                REG_MID:  n_breaks.mid  = pwdata[FRAC_W-1:0];
                REG_HIGH: n_breaks.high = pwdata[FRAC_W-1:0];
                default:  n_breaks = r_breaks;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_breaks.low  <= LOW_RST;
            r_breaks.mid  <= MID_RST;
            r_breaks.high <= HIGH_RST;
        end else begin
            r_breaks <= n_breaks;
        end
    end

    always_comb begin
        unique case (idx)
            REG_LOW:  prdata = DATA_W'(r_breaks.low);
            REG_MID:  prdata = DATA_W'(r_breaks.mid);
            REG_HIGH: prdata = DATA_W'(r_breaks.high);
            default:  prdata = '0;
        endcase
    end

    assign o_breaks = r_breaks;

endmodule

// ===== sv/bhcm_select.sv =====
// ----------------------------------------------------------------------------
// bhcm_select: segment select and dividend scaling
// Stage 1 picks the segment and its num/den; stage 2 forms num*255.
// ----------------------------------------------------------------------------
module bhcm_select
    import bhcm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [FRAC_W-1:0] i_magnitude,
    input  t_breaks           i_breaks,
    output logic              o_valid,
    output t_div_data         o_data
);

    logic             r_a_valid;
    t_seg             r_a_seg;
    logic [ONE_W-1:0] r_a_num;
    logic [ONE_W-1:0] r_a_den;

    t_seg             n_a_seg;
    logic [ONE_W-1:0] n_a_num;
    logic [ONE_W-1:0] n_a_den;
    logic [ONE_W-1:0] m;
    logic [ONE_W-1:0] k1;
    logic [ONE_W-1:0] k2;
    logic [ONE_W-1:0] k3;

    logic             r_b_valid;
    t_div_data        r_b_data;

    assign m  = ONE_W'(i_magnitude);
    assign k1 = ONE_W'(i_breaks.low);
    assign k2 = ONE_W'(i_breaks.mid);
    assign k3 = ONE_W'(i_breaks.high);

    always_comb begin
        if (m > k3) begin
            n_a_seg = SEG_HOT;
            n_a_num = ONE - m;
            n_a_den = ONE - k3;
        end else if (m > k2) begin
            n_a_seg = SEG_WARM;
            n_a_num = m - k2;
            n_a_den = k3 - k2;
        end else if (m > k1) begin
            n_a_seg = SEG_COOL;
            n_a_num = m - k1;
            n_a_den = k2 - k1;
        end else begin
            n_a_seg = SEG_COLD;
            // zero low breakpoint: limit is full scale (white)
            if (k1 == '0) begin
                n_a_num = ONE_W'(1);
                n_a_den = ONE_W'(1);
            end else begin
                n_a_num = k1 - m;
                n_a_den = k1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_seg       <= n_a_seg;
        r_a_num       <= n_a_num;
        r_a_den       <= n_a_den;
        r_b_data.seg  <= r_a_seg;
        r_b_data.den  <= r_a_den;
        // num * 255 = num * 256 - num
        r_b_data.rem  <= {r_a_num, {QUO_W{1'b0}}} - REM_W'(r_a_num);
        r_b_data.quo  <= '0;
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

    // num never exceeds den, so the quotient stays within 0..255
    a_num_le_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (r_a_num <= r_a_den) && (r_a_den != '0))
        else $error("bhcm_select: num/den out of range");

endmodule

// ===== sv/bhcm_div.sv =====
// ----------------------------------------------------------------------------
// bhcm_div: pipelined restoring divider
// One quotient bit per stage, MSB first, QUO_W stages.
// ----------------------------------------------------------------------------
module bhcm_div
    import bhcm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_div_data i_data,
    output logic      o_valid,
    output t_div_data o_data
);

    logic      r_vld [1:QUO_W];
    t_div_data r_stg [1:QUO_W];

    for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
        localparam int B = QUO_W - k;

        logic             src_vld;
        t_div_data        src;
        t_div_data        n_stg;
        logic [REM_W-1:0] shifted;
        logic [REM_W:0]   trial;

        if (k == 1) begin : g_first
            assign src_vld = i_valid;
            assign src     = i_data;
        end else begin : g_next
            assign src_vld = r_vld[k-1];
            assign src     = r_stg[k-1];
        end

        assign shifted = REM_W'(src.den) << B;
        assign trial   = {1'b0, src.rem} - {1'b0, shifted};

        always_comb begin
            n_stg = src;
            if (!trial[REM_W]) begin
                n_stg.rem    = trial[REM_W-1:0];
                n_stg.quo[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_stg[k] <= n_stg;
        end
    end

    assign o_valid = r_vld[QUO_W];
    assign o_data  = r_stg[QUO_W];

    // after the last bit the remainder is below the divisor
    a_rem_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QUO_W] |-> (r_stg[QUO_W].rem < REM_W'(r_stg[QUO_W].den)))
        else $error("bhcm_div: remainder not reduced");

    a_vld_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##QUO_W r_vld[QUO_W])
        else $error("bhcm_div: valid lost in pipe");

endmodule

// ===== sv/breakpoint_heat_colormap_unit.sv =====
// ----------------------------------------------------------------------------
// breakpoint_heat_colormap_unit: Q0.16 magnitude to RGB heat colormap
// Throughput: one item per cycle; busy is never asserted.
// Depth set by the 8-stage divider (one quotient bit per stage) plus
// segment select, dividend scaling and color output registers.
// Reset (i_rst_n, synchronous, active low) flushes all in-flight items
// and restores the default breakpoints 655 / 3277 / 9830.
// ----------------------------------------------------------------------------
module breakpoint_heat_colormap_unit
    import bhcm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // item interface
    input  logic              start,
    output logic              busy,
    input  logic [FRAC_W-1:0] i_magnitude,
    output logic              o_valid,
    output logic [QUO_W-1:0]  o_red,
    output logic [QUO_W-1:0]  o_green,
    output logic [QUO_W-1:0]  o_blue,
    // APB config port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_breaks          breaks;
    logic             sel_valid;
    t_div_data        sel_data;
    logic             div_valid;
    t_div_data        div_data;

    logic             r_valid;
    logic [QUO_W-1:0] r_red;
    logic [QUO_W-1:0] r_green;
    logic [QUO_W-1:0] r_blue;
    logic [QUO_W-1:0] n_red;
    logic [QUO_W-1:0] n_green;
    logic [QUO_W-1:0] n_blue;
    logic [QUO_W-1:0] t;

    // no back-pressure anywhere: a transfer is taken every cycle
    assign busy = 1'b0;

    bhcm_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_breaks (breaks)
    );

    // stages 1-2: segment pick, num/den, num*255
    bhcm_select u_select (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start & ~busy),
        .i_magnitude (i_magnitude),
        .i_breaks    (breaks),
        .o_valid     (sel_valid),
        .o_data      (sel_data)
    );

    // stages 3-10: t = num*255/den, truncated
    bhcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sel_valid),
        .i_data  (sel_data),
        .o_valid (div_valid),
        .o_data  (div_data)
    );

    // stage 11: map t onto the channels of its segment
    assign t = div_data.quo;

    always_comb begin
        case (div_data.seg)
            SEG_HOT: begin
                n_red   = t;
                n_green = '0;
                n_blue  = '0;
            end
            SEG_WARM: begin
                n_red   = t;
                n_green = QMAX - t;
                n_blue  = '0;
            end
            SEG_COOL: begin
                n_red   = '0;
                n_green = t;
                n_blue  = QMAX - t;
            end
            default: begin   // cold: white fading to blue
                n_red   = t;
                n_green = t;
                n_blue  = QMAX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    // every result comes from an earlier start transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("heat colormap: result without a transfer");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_valid)
        else $error("heat colormap: transfer lost");

    // full blue only in cold or cool-at-zero: red and green match then
    a_blue_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_blue == QMAX)) |-> (o_red == o_green))
        else $error("heat colormap: bad color at full blue");

endmodule
